@@ src/gmb_pkg.sv @@
package gmb_pkg;

  localparam int GridSide  = 8;
  localparam int CoordW    = 3;
  localparam int CellCount = GridSide * GridSide;
  localparam int DistW     = 6;

  // direction codes, also wall mask bit positions
  localparam logic [1:0] DIR_PY = 2'd0;
  localparam logic [1:0] DIR_PX = 2'd1;
  localparam logic [1:0] DIR_NY = 2'd2;
  localparam logic [1:0] DIR_NX = 2'd3;

  localparam logic [1:0] ST_STEP   = 2'd0;
  localparam logic [1:0] ST_SAME   = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_RUN   = 1'b1;

  // broadcast control from sequencer to every cell
  typedef struct packed {
    logic              wr;
    logic              init;
    logic              flood;
    logic              step;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] tx;
    logic [CoordW-1:0] ty;
    logic [3:0]        mask;
    logic [DistW-1:0]  wave;
    logic [DistW-1:0]  want;
    logic [3:0]        chosen;
  } cell_ctl_t;

  // signals seen from the four neighbors, indexed by direction
  typedef struct packed {
    logic [3:0] vis;
    logic [3:0] cur;
    logic [3:0] open;
  } nbr_t;

endpackage

@@ src/gmb_cell.sv @@
module gmb_cell
  import gmb_pkg::*;
#(
  parameter logic [CoordW-1:0] CX = '0,
  parameter logic [CoordW-1:0] CY = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  nbr_t             nbr,
  output logic             vis,
  output logic             cur,
  output logic [3:0]       wall,
  output logic [DistW-1:0] hops,
  output logic             hit,
  output logic [3:0]       cand
);

  logic             vis_r, vis_nxt;
  logic             cur_r, cur_nxt;
  logic [3:0]       wall_r, wall_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;
  logic             reach;
  logic             match;

  assign reach = |(nbr.vis & nbr.open);
  assign hit   = ctl.flood && !vis_r && reach;
  assign match = vis_r && (dist_r == ctl.want);

  // neighbor toward cur in direction e: cur reaches me moving (e+2)&3
  always_comb begin
    cand[DIR_NY] = match && nbr.cur[DIR_PY] && !wall_r[DIR_PY];
    cand[DIR_NX] = match && nbr.cur[DIR_PX] && !wall_r[DIR_PX];
    cand[DIR_PY] = match && nbr.cur[DIR_NY] && !wall_r[DIR_NY];
    cand[DIR_PX] = match && nbr.cur[DIR_NX] && !wall_r[DIR_NX];
  end

  always_comb begin
    vis_nxt  = vis_r;
    cur_nxt  = cur_r;
    wall_nxt = wall_r;
    dist_nxt = dist_r;
    if (ctl.wr && ctl.x == CX && ctl.y == CY) begin
      wall_nxt = ctl.mask;
    end
    if (ctl.init) begin
      vis_nxt  = (ctl.x == CX) && (ctl.y == CY);
      dist_nxt = '0;
      cur_nxt  = (ctl.tx == CX) && (ctl.ty == CY);
    end
    if (hit) begin
      vis_nxt  = 1'b1;
      dist_nxt = ctl.wave;
    end
    if (ctl.step) begin
      cur_nxt = |(cand & ctl.chosen);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r  <= 1'b0;
      cur_r  <= 1'b0;
      wall_r <= '0;
      dist_r <= '0;
    end else begin
      vis_r  <= vis_nxt;
      cur_r  <= cur_nxt;
      wall_r <= wall_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign vis  = vis_r;
  assign cur  = cur_r;
  assign wall = wall_r;
  assign hops = dist_r;

endmodule

@@ src/grid_maze_bfs_path_finder.sv @@
// Shortest-path finder for an 8x8 walled maze. A write request (tuser = 0) stores the wall
// mask of one cell and returns nothing. A run request (tuser = 1) floods distances from
// the start cell through a 2D array of cells: every cycle each unvisited cell whose
// neighbor is visited and open toward it takes the current wave number, until no cell is
// newly reached; a check step follows that tests the target. The path is then walked from
// the target, one cell per cycle while out_tready allows; at each step the open neighbors
// of the current cell that lie one level nearer the start flag themselves, and the first
// in order +Y,+X,-Y,-X wins. Results come out target side first, start cell last with
// tlast set; move_dir is the move from that cell toward the target. tuser on the output:
// 0 path step, 1 target equals start, 2 target unreachable. New requests are taken only
// when the previous run has finished.
module grid_maze_bfs_path_finder
  import gmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_x[2:0], cell_y[5:3], wall_mask[9:6], target_x[12:10], target_y[15:13]
  input  logic [15:0] in_tdata,
  // action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // path_x[2:0], path_y[5:3], move_dir[7:6], distance[13:8], zero pad
  output logic [15:0] out_tdata,
  // status
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLOOD = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_TRACE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [DistW-1:0]  wave_r, wave_nxt;
  logic [DistW-1:0]  cd_r, cd_nxt;
  logic [CoordW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CoordW-1:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic [CoordW-1:0] px_r, px_nxt, py_r, py_nxt;

  logic              ov_r, ov_nxt;
  logic [15:0]       od_r, od_nxt;
  logic [1:0]        ou_r, ou_nxt;
  logic              ol_r, ol_nxt;

  cell_ctl_t         ctl;
  logic              in_acc;
  logic              out_free;

  logic [CellCount-1:0]  vis_v, cur_v, hit_v;
  logic [3:0]            wall_v [CellCount];
  logic [DistW-1:0]      dist_v [CellCount];
  logic [3:0]            cand_v [CellCount];

  logic                  any_new;
  logic                  tgt_vis;
  logic [DistW-1:0]      tgt_dist;
  logic [3:0]            cand_or;
  logic [3:0]            chosen;
  logic [1:0]            dsel;
  logic [DistW-1:0]      want;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;
  assign want      = cd_r - DistW'(1);

  // reductions over the array
  always_comb begin
    tgt_dist = '0;
    cand_or  = '0;
    for (int i = 0; i < CellCount; i++) begin
      tgt_dist = tgt_dist | (dist_v[i] & {DistW{cur_v[i]}});
      cand_or  = cand_or | cand_v[i];
    end
  end
  assign any_new = |hit_v;
  assign tgt_vis = |(vis_v & cur_v);

  // first direction in +Y,+X,-Y,-X order
  always_comb begin
    priority if (cand_or[DIR_PY]) begin
      dsel = DIR_PY;
    end else if (cand_or[DIR_PX]) begin
      dsel = DIR_PX;
    end else if (cand_or[DIR_NY]) begin
      dsel = DIR_NY;
    end else begin
      dsel = DIR_NX;
    end
    chosen = 4'b0001 << dsel;
  end

  always_comb begin
    ctl        = '0;
    ctl.x      = in_tdata[2:0];
    ctl.y      = in_tdata[5:3];
    ctl.mask   = in_tdata[9:6];
    ctl.tx     = in_tdata[12:10];
    ctl.ty     = in_tdata[15:13];
    ctl.wave   = wave_r;
    ctl.want   = want;
    ctl.chosen = chosen;
    ctl.wr     = in_acc && (in_tuser == ACT_WRITE);
    ctl.init   = in_acc && (in_tuser == ACT_RUN);
    ctl.flood  = (state_r == S_FLOOD);
    ctl.step   = (state_r == S_TRACE) && out_free;
  end

  // cell array, neighbor wiring by direction
  for (genvar gx = 0; gx < GridSide; gx++) begin : g_x
    for (genvar gy = 0; gy < GridSide; gy++) begin : g_y
      localparam int Idx = gx * GridSide + gy;
      // neighbor indexes, held on the cell itself at the grid edge (masked below)
      localparam int IdxPY = (gy < GridSide - 1) ? Idx + 1 : Idx;
      localparam int IdxPX = (gx < GridSide - 1) ? Idx + GridSide : Idx;
      localparam int IdxNY = (gy > 0) ? Idx - 1 : Idx;
      localparam int IdxNX = (gx > 0) ? Idx - GridSide : Idx;
      nbr_t nb;
      always_comb begin
        nb = '0;
        if (gy < GridSide - 1) begin
          nb.vis[DIR_PY]  = vis_v[IdxPY];
          nb.cur[DIR_PY]  = cur_v[IdxPY];
          nb.open[DIR_PY] = !wall_v[IdxPY][DIR_NY];
        end
        if (gx < GridSide - 1) begin
          nb.vis[DIR_PX]  = vis_v[IdxPX];
          nb.cur[DIR_PX]  = cur_v[IdxPX];
          nb.open[DIR_PX] = !wall_v[IdxPX][DIR_NX];
        end
        if (gy > 0) begin
          nb.vis[DIR_NY]  = vis_v[IdxNY];
          nb.cur[DIR_NY]  = cur_v[IdxNY];
          nb.open[DIR_NY] = !wall_v[IdxNY][DIR_PY];
        end
        if (gx > 0) begin
          nb.vis[DIR_NX]  = vis_v[IdxNX];
          nb.cur[DIR_NX]  = cur_v[IdxNX];
          nb.open[DIR_NX] = !wall_v[IdxNX][DIR_PX];
        end
      end
      gmb_cell #(
        .CX(CoordW'(gx)),
        .CY(CoordW'(gy))
      ) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .nbr  (nb),
        .vis  (vis_v[Idx]),
        .cur  (cur_v[Idx]),
        .wall (wall_v[Idx]),
        .hops (dist_v[Idx]),
        .hit  (hit_v[Idx]),
        .cand (cand_v[Idx])
      );
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    wave_nxt  = wave_r;
    cd_nxt    = cd_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    ol_nxt    = ol_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.init) begin
          sx_nxt    = ctl.x;
          sy_nxt    = ctl.y;
          tx_nxt    = ctl.tx;
          ty_nxt    = ctl.ty;
          wave_nxt  = DistW'(1);
          state_nxt = S_FLOOD;
        end
      end
      S_FLOOD: begin
        wave_nxt = wave_r + DistW'(1);
        if (!any_new) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          od_nxt = {10'd0, ty_r, tx_r};
          if (!tgt_vis) begin
            ou_nxt    = ST_UNREACH;
            state_nxt = S_IDLE;
          end else if (tgt_dist == '0) begin
            ou_nxt    = ST_SAME;
            od_nxt    = {10'd0, sy_r, sx_r};
            state_nxt = S_IDLE;
          end else begin
            ov_nxt    = 1'b0;
            cd_nxt    = tgt_dist;
            px_nxt    = tx_r;
            py_nxt    = ty_r;
            state_nxt = S_TRACE;
          end
        end
      end
      S_TRACE: begin
        if (out_free) begin
          unique case (dsel)
            DIR_PY: py_nxt = py_r + CoordW'(1);
            DIR_PX: px_nxt = px_r + CoordW'(1);
            DIR_NY: py_nxt = py_r - CoordW'(1);
            DIR_NX: px_nxt = px_r - CoordW'(1);
            default: py_nxt = py_r;
          endcase
          ov_nxt = 1'b1;
          ou_nxt = ST_STEP;
          ol_nxt = (want == '0);
          od_nxt = {2'd0, want, dsel + 2'd2, py_nxt, px_nxt};
          cd_nxt = want;
          if (want == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    wave_r <= wave_nxt;
    cd_r   <= cd_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  a_cur_single: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cur_v))
    else $error("more than one current cell");
  a_trace_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRACE) |-> (cand_or != '0))
    else $error("walk back found no nearer neighbor");
  a_trace_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRACE) |-> (tgt_vis && cd_r != '0))
    else $error("walk back on an unvisited cell");
  // wave wraps to zero only after the deepest possible level, when nothing is left
  a_flood_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLOOD && wave_r == '0) |-> !any_new)
    else $error("flood wave overflow");

endmodule
